// File: design/bfth_pkg.sv
// bfth_pkg: shared types, constants and state codes for the three-hash bloom filter
package bfth_pkg;

   localparam int FILTER_BITS_DEFAULT = 65536;
   localparam int HASH_W = 32;
   localparam int WORD_W = 32;
   localparam int WORD_SEL_W = $clog2(WORD_W);
   localparam logic [HASH_W-1:0] DJB_INIT = 32'd5381;

   localparam logic OP_ADD = 1'b0;
   localparam logic OP_CHECK = 1'b1;

   localparam logic [1:0] HASH_LAST = 2'd2;

   typedef struct packed {
      logic       operation;
      logic [7:0] key_byte;
      logic       last;
   } req_type;

   typedef struct packed {
      logic done_operation;
      logic possibly_present;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FIN1,
      ST_FIN2,
      ST_MUL,
      ST_SUB,
      ST_MOD,
      ST_READ,
      ST_WRITE,
      ST_DONE
   } state_type;

endpackage

// File: design/bloom_filter_three_hash.sv
// bloom_filter_three_hash: byte-serial three-hash bloom filter with a word-wide bit memory
//
// req channel: one key byte per transaction with operation and last mark. A zero byte
// ends the key; it and later bytes of that key are not hashed. Operation is taken
// from the transaction marked last.
// rsp channel: one transaction per key, done_operation echoes the operation and
// possibly_present is the check answer (0 for an add).
// Non-last bytes are taken one per cycle. After a last byte the request side stalls
// through hash finalization (FIN1, FIN2), modulo reduction of the three hashes in
// parallel (reciprocal multiply, multiply and subtract, final correction), three
// read/write pairs on the bit memory and the load of the result register in DONE.
// The result register lets the next key stream in while a result waits; if the
// previous result is still stalled when the next one is ready, the block waits.
// After reset the bit memory is cleared one 32-bit row per cycle, all ceil(FILTER_BITS/32)
// rows (2048 at the default size), while req_stall stays high.
// Reset is synchronous and active high.
module bloom_filter_three_hash #(
   parameter int FILTER_BITS = bfth_pkg::FILTER_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  bfth_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output bfth_pkg::rsp_type rsp_data
);

   localparam int POS_W = ($clog2(FILTER_BITS) > bfth_pkg::WORD_SEL_W) ?
                          $clog2(FILTER_BITS) : bfth_pkg::WORD_SEL_W + 1;
   localparam int ROW_W = POS_W - bfth_pkg::WORD_SEL_W;
   localparam int ROWS = (FILTER_BITS + bfth_pkg::WORD_W - 1) / bfth_pkg::WORD_W;
   localparam int HW = bfth_pkg::HASH_W;
   localparam logic [HW-1:0] RECIP = HW'((64'd1 << HW) / FILTER_BITS);
   localparam logic [POS_W:0] FB_W = (POS_W+1)'(FILTER_BITS);

   // quotient estimate is exact or one low, so the difference stays below 2*FILTER_BITS
   function automatic logic [POS_W:0] mod_sub(input logic [HW-1:0] x,
                                              input logic [HW-1:0] q);
      logic [POS_W:0] m;
      m = q[POS_W:0] * FB_W;
      return x[POS_W:0] - m;
   endfunction

   function automatic logic [POS_W-1:0] mod_fold(input logic [POS_W:0] t);
      logic [POS_W:0] u;
      u = t;
      if (t >= FB_W) begin
         u = t - FB_W;
      end
      return u[POS_W-1:0];
   endfunction

   bfth_pkg::state_type state_ff, state_in;
   logic [ROW_W-1:0] clr_ff, clr_in;
   logic [HW-1:0] djb_ff, djb_in, sdbm_ff, sdbm_in, oaat_ff, oaat_in;
   logic ended_ff, ended_in;
   logic op_ff, op_in;
   logic hit_ff, hit_in;
   logic [1:0] sel_ff, sel_in;
   logic [HW-1:0] q1_ff, q1_in, q2_ff, q2_in, q3_ff, q3_in;
   logic [POS_W-1:0] r1_ff, r1_in, r2_ff, r2_in, r3_ff, r3_in;
   logic rsp_valid_ff, rsp_valid_in;
   bfth_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic [bfth_pkg::WORD_W-1:0] mem [ROWS];
   logic [bfth_pkg::WORD_W-1:0] rd_data_ff;
   logic mem_we;
   logic [ROW_W-1:0] mem_waddr;
   logic [bfth_pkg::WORD_W-1:0] mem_wdata;

   logic [POS_W-1:0] cur_pos;
   logic [ROW_W-1:0] cur_row;
   logic [bfth_pkg::WORD_SEL_W-1:0] cur_bit;
   logic [HW-1:0] byte_ext, djb_abs, sdbm_abs, oaat_t1, oaat_t2, oaat_abs, fin_x, fin2;
   logic [2*HW-1:0] djb_prod, sdbm_prod, oaat_prod;

   assign byte_ext = HW'(req_data.key_byte);
   assign djb_abs = (djb_ff << 5) + djb_ff + byte_ext;
   assign sdbm_abs = byte_ext + (sdbm_ff << 6) + (sdbm_ff << 16) - sdbm_ff;
   assign oaat_t1 = oaat_ff + byte_ext;
   assign oaat_t2 = oaat_t1 + (oaat_t1 << 10);
   assign oaat_abs = oaat_t2 ^ (oaat_t2 >> 6);
   assign fin_x = oaat_ff ^ (oaat_ff >> 11);
   assign fin2 = fin_x + (fin_x << 15);

   assign djb_prod = (2*HW)'(djb_ff) * (2*HW)'(RECIP);
   assign sdbm_prod = (2*HW)'(sdbm_ff) * (2*HW)'(RECIP);
   assign oaat_prod = (2*HW)'(oaat_ff) * (2*HW)'(RECIP);

   always_comb begin
      case (sel_ff)
         2'd0: cur_pos = r1_ff;
         2'd1: cur_pos = r2_ff;
         default: cur_pos = r3_ff;
      endcase
   end

   assign cur_row = cur_pos[POS_W-1:bfth_pkg::WORD_SEL_W];
   assign cur_bit = cur_pos[bfth_pkg::WORD_SEL_W-1:0];

   always_comb begin
      state_in = state_ff;
      clr_in = clr_ff;
      djb_in = djb_ff;
      sdbm_in = sdbm_ff;
      oaat_in = oaat_ff;
      ended_in = ended_ff;
      op_in = op_ff;
      hit_in = hit_ff;
      sel_in = sel_ff;
      q1_in = q1_ff;
      q2_in = q2_ff;
      q3_in = q3_ff;
      r1_in = r1_ff;
      r2_in = r2_ff;
      r3_in = r3_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in = rsp_data_ff;
      req_stall = (state_ff != bfth_pkg::ST_IDLE);
      mem_we = 1'b0;
      mem_waddr = cur_row;
      mem_wdata = rd_data_ff | (bfth_pkg::WORD_W'(1) << cur_bit);
      case (state_ff)
         bfth_pkg::ST_CLEAR: begin
            mem_we = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
            if (clr_ff == ROW_W'(ROWS - 1)) begin
               state_in = bfth_pkg::ST_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         bfth_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (!ended_ff) begin
                  if (req_data.key_byte == 8'd0) begin
                     ended_in = 1'b1;
                  end else begin
                     djb_in = djb_abs;
                     sdbm_in = sdbm_abs;
                     oaat_in = oaat_abs;
                  end
               end
               if (req_data.last) begin
                  op_in = req_data.operation;
                  state_in = bfth_pkg::ST_FIN1;
               end
            end
         end
         bfth_pkg::ST_FIN1: begin
            oaat_in = oaat_ff + (oaat_ff << 3);
            state_in = bfth_pkg::ST_FIN2;
         end
         bfth_pkg::ST_FIN2: begin
            oaat_in = fin2;
            state_in = bfth_pkg::ST_MUL;
         end
         bfth_pkg::ST_MUL: begin
            q1_in = djb_prod[2*HW-1:HW];
            q2_in = sdbm_prod[2*HW-1:HW];
            q3_in = oaat_prod[2*HW-1:HW];
            state_in = bfth_pkg::ST_SUB;
         end
         bfth_pkg::ST_SUB: begin
            q1_in = HW'(mod_sub(djb_ff, q1_ff));
            q2_in = HW'(mod_sub(sdbm_ff, q2_ff));
            q3_in = HW'(mod_sub(oaat_ff, q3_ff));
            state_in = bfth_pkg::ST_MOD;
         end
         bfth_pkg::ST_MOD: begin
            r1_in = mod_fold(q1_ff[POS_W:0]);
            r2_in = mod_fold(q2_ff[POS_W:0]);
            r3_in = mod_fold(q3_ff[POS_W:0]);
            sel_in = 2'd0;
            hit_in = 1'b1;
            state_in = bfth_pkg::ST_READ;
         end
         bfth_pkg::ST_READ: begin
            state_in = bfth_pkg::ST_WRITE;
         end
         bfth_pkg::ST_WRITE: begin
            if (op_ff == bfth_pkg::OP_ADD) begin
               mem_we = 1'b1;
            end else begin
               hit_in = hit_ff & rd_data_ff[cur_bit];
            end
            if (sel_ff == bfth_pkg::HASH_LAST) begin
               state_in = bfth_pkg::ST_DONE;
            end else begin
               sel_in = sel_ff + 1'b1;
               state_in = bfth_pkg::ST_READ;
            end
         end
         bfth_pkg::ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in.done_operation = op_ff;
               rsp_data_in.possibly_present = (op_ff == bfth_pkg::OP_CHECK) && hit_ff;
               djb_in = bfth_pkg::DJB_INIT;
               sdbm_in = '0;
               oaat_in = '0;
               ended_in = 1'b0;
               state_in = bfth_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bfth_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bfth_pkg::ST_CLEAR;
         clr_ff <= '0;
         djb_ff <= bfth_pkg::DJB_INIT;
         sdbm_ff <= '0;
         oaat_ff <= '0;
         ended_ff <= 1'b0;
         sel_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         djb_ff <= djb_in;
         sdbm_ff <= sdbm_in;
         oaat_ff <= oaat_in;
         ended_ff <= ended_in;
         sel_ff <= sel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
      hit_ff <= hit_in;
      q1_ff <= q1_in;
      q2_ff <= q2_in;
      q3_ff <= q3_in;
      r1_ff <= r1_in;
      r2_ff <= r2_in;
      r3_ff <= r3_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[cur_row];
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == bfth_pkg::ST_DONE))
      else $error("result raised outside the done state");

   a_add_not_present: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.done_operation == bfth_pkg::OP_ADD)
      |-> !rsp_data_ff.possibly_present)
      else $error("add transaction reports a hit");

   a_no_write_on_check: assert property (@(posedge clock) disable iff (reset)
      (mem_we && state_ff != bfth_pkg::ST_CLEAR) |-> (op_ff == bfth_pkg::OP_ADD))
      else $error("bit memory written during a check");

   a_write_after_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bfth_pkg::ST_WRITE) |-> $past(state_ff == bfth_pkg::ST_READ))
      else $error("read-modify-write without a preceding read");

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> (rsp_valid_ff && $stable(rsp_data_ff)))
      else $error("stalled result changed");

endmodule
